// File: rtl/core/dwd_pkg.sv
// Shared constants, types and table functions for the date difference block.
// Used by dwd_date_calc and date_difference_and_weekday; no dependencies.
`default_nettype none

package dwd_pkg;

  localparam int YEAR_W   = 14;
  localparam int MONTH_W  = 4;
  localparam int DAY_W    = 5;
  localparam int SERIAL_W = 22;
  localparam int WSUM_W   = 14;
  localparam int LEAP_W   = 12;
  localparam int Q100_W   = 7;
  localparam int WDAY_W   = 3;

  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 32;

  localparam logic [YEAR_W-1:0]  YEAR_MIN  = YEAR_W'(1);
  localparam logic [YEAR_W-1:0]  YEAR_MAX  = YEAR_W'(9999);
  localparam logic [MONTH_W-1:0] MONTH_MIN = MONTH_W'(1);
  localparam logic [MONTH_W-1:0] MONTH_MAX = MONTH_W'(12);
  localparam logic [MONTH_W-1:0] MONTH_FEB = MONTH_W'(2);
  localparam logic [DAY_W-1:0]   DAY_MIN   = DAY_W'(1);

  localparam logic [8:0]  DAYS_PER_YEAR = 9'd365;
  // floor(y / 100) == (y * 5243) >> 19 for y up to 9999
  localparam logic [12:0] RECIP_100     = 13'd5243;
  localparam int          SHIFT_100     = 19;
  // floor(w / 7) == (w * 9363) >> 16 for w below 12500
  localparam logic [13:0] RECIP_7       = 14'd9363;
  localparam int          SHIFT_7       = 16;

  typedef struct packed {
    logic ld2;
    logic ld3;
  } dwd_ctl_t;

  function automatic logic [8:0] days_before_month(input logic [MONTH_W-1:0] idx);
    logic [8:0] res;
    case (idx)
      4'd0:    res = 9'd0;
      4'd1:    res = 9'd31;
      4'd2:    res = 9'd59;
      4'd3:    res = 9'd90;
      4'd4:    res = 9'd120;
      4'd5:    res = 9'd151;
      4'd6:    res = 9'd181;
      4'd7:    res = 9'd212;
      4'd8:    res = 9'd243;
      4'd9:    res = 9'd273;
      4'd10:   res = 9'd304;
      4'd11:   res = 9'd334;
      default: res = 9'd0;
    endcase
    return res;
  endfunction

  function automatic logic [2:0] weekday_offset(input logic [MONTH_W-1:0] idx);
    logic [2:0] res;
    case (idx)
      4'd0:    res = 3'd0;
      4'd1:    res = 3'd3;
      4'd2:    res = 3'd2;
      4'd3:    res = 3'd5;
      4'd4:    res = 3'd0;
      4'd5:    res = 3'd3;
      4'd6:    res = 3'd5;
      4'd7:    res = 3'd1;
      4'd8:    res = 3'd4;
      4'd9:    res = 3'd6;
      4'd10:   res = 3'd2;
      4'd11:   res = 3'd4;
      default: res = 3'd0;
    endcase
    return res;
  endfunction

  // Remainder by 7 through a reciprocal multiply; q*7 is done as shift and subtract.
  function automatic logic [WDAY_W-1:0] mod7(input logic [WSUM_W-1:0] w);
    logic [2*WSUM_W-1:0] prod;
    logic [WSUM_W-1:0]   q;
    logic [WSUM_W-1:0]   r;
    prod = w * RECIP_7;
    q    = WSUM_W'(prod >> SHIFT_7);
    r    = w - ((q << 3) - q);
    return r[WDAY_W-1:0];
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/date_difference_and_weekday.sv
// Top level: days between two Gregorian dates and the weekday of each.
// Depends on dwd_pkg and dwd_date_calc (one instance per date).
//
//   channel  direction  tdata fields (low bit first)                    tuser
//   s_axis   in         first_year, first_month, first_day,             -
//                       second_year, second_month, second_day
//   m_axis   out        days_between, first_weekday, second_weekday     valid_res
//
// Four register stages: input, year split, serial sum, result. One word per cycle while
// the output is not stalled; a word passes the stages in order. The multiplies by the
// reciprocals of 100 and 7 and by 365 each sit alone in a stage.
// Reset clears the stage valid bits only. Each stage takes a new word when it is empty
// or its word moves on, so bubbles close up while the output is stalled.
`default_nettype none

module date_difference_and_weekday (
  input  wire                               clk,
  input  wire                               rst,
  input  wire                               s_axis_tvalid,
  output logic                              s_axis_tready,
  // [13:0] first_year, [17:14] first_month, [22:18] first_day, [36:23] second_year,
  // [40:37] second_month, [45:41] second_day, [47:46] zero
  input  wire  [dwd_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  output logic                              m_axis_tvalid,
  input  wire                               m_axis_tready,
  // [21:0] days_between, [24:22] first_weekday, [27:25] second_weekday, [31:28] zero
  output logic [dwd_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
  // [0] valid_res
  output logic                              m_axis_tuser
);
  import dwd_pkg::*;

  logic v1, v2, v3;
  logic rdy1, rdy2, rdy3, rdy4;
  dwd_ctl_t ctl;

  logic [YEAR_W-1:0]  yr_a, yr_b;
  logic [MONTH_W-1:0] mo_a, mo_b;
  logic [DAY_W-1:0]   dy_a, dy_b;

  logic [SERIAL_W-1:0] serial_a, serial_b;
  logic [WSUM_W-1:0]   wsum_a, wsum_b;
  logic                ok_a, ok_b;

  logic [SERIAL_W-1:0] diff_next;
  logic [WDAY_W-1:0]   wd_a_next, wd_b_next;
  logic                both_ok;

  logic [SERIAL_W-1:0] days_between;
  logic [WDAY_W-1:0]   first_weekday, second_weekday;
  logic                valid_res;

  // ready chain from the output back
  assign rdy4 = !m_axis_tvalid || m_axis_tready;
  assign rdy3 = !v3 || rdy4;
  assign rdy2 = !v2 || rdy3;
  assign rdy1 = !v1 || rdy2;
  assign s_axis_tready = rdy1;
  assign ctl.ld2 = rdy2;
  assign ctl.ld3 = rdy3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1            <= 1'b0;
      v2            <= 1'b0;
      v3            <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (rdy1) v1 <= s_axis_tvalid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
      if (rdy4) m_axis_tvalid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      yr_a <= s_axis_tdata[13:0];
      mo_a <= s_axis_tdata[17:14];
      dy_a <= s_axis_tdata[22:18];
      yr_b <= s_axis_tdata[36:23];
      mo_b <= s_axis_tdata[40:37];
      dy_b <= s_axis_tdata[45:41];
    end
  end

  dwd_date_calc u_first (
    .clk    (clk),
    .ctl    (ctl),
    .year   (yr_a),
    .month  (mo_a),
    .day    (dy_a),
    .serial (serial_a),
    .wsum   (wsum_a),
    .ok     (ok_a)
  );

  dwd_date_calc u_second (
    .clk    (clk),
    .ctl    (ctl),
    .year   (yr_b),
    .month  (mo_b),
    .day    (dy_b),
    .serial (serial_b),
    .wsum   (wsum_b),
    .ok     (ok_b)
  );

  // zero every field when either date is out of range
  always_comb begin
    both_ok   = ok_a && ok_b;
    diff_next = (serial_b >= serial_a) ? serial_b - serial_a : serial_a - serial_b;
    wd_a_next = mod7(wsum_a);
    wd_b_next = mod7(wsum_b);
    if (!both_ok) begin
      diff_next = '0;
      wd_a_next = '0;
      wd_b_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy4) begin
      days_between   <= diff_next;
      first_weekday  <= wd_a_next;
      second_weekday <= wd_b_next;
      valid_res      <= both_ok;
    end
  end

  assign m_axis_tdata = {(OUT_DATA_W - SERIAL_W - 2*WDAY_W)'(0),
                         second_weekday, first_weekday, days_between};
  assign m_axis_tuser = valid_res;

endmodule

`default_nettype wire

// File: rtl/core/dwd_date_calc.sv
// Two-stage day serial and weekday sum for one date.
// Depends on dwd_pkg for tables, constants and the stage load struct.
`default_nettype none

module dwd_date_calc (
  input  wire                            clk,
  input  dwd_pkg::dwd_ctl_t              ctl,
  input  wire  [dwd_pkg::YEAR_W-1:0]     year,
  input  wire  [dwd_pkg::MONTH_W-1:0]    month,
  input  wire  [dwd_pkg::DAY_W-1:0]      day,
  output logic [dwd_pkg::SERIAL_W-1:0]   serial,
  output logic [dwd_pkg::WSUM_W-1:0]     wsum,
  output logic                           ok
);
  import dwd_pkg::*;

  // first stage: shifted year, year/100, month index
  logic [YEAR_W-1:0]      yy_next;
  logic [MONTH_W-1:0]     midx_next;
  logic [YEAR_W+12:0]     prod100;
  logic [Q100_W-1:0]      q100_next;
  logic                   ok_next;

  logic [YEAR_W-1:0]      yy;
  logic [MONTH_W-1:0]     midx;
  logic [Q100_W-1:0]      q100;
  logic [DAY_W-1:0]       dy;
  logic                   ok2;

  // second stage: leap count, serial, weekday sum
  logic [LEAP_W-1:0]      leap;
  logic [SERIAL_W-1:0]    serial_next;
  logic [WSUM_W-1:0]      wsum_next;

  always_comb begin
    ok_next   = (year >= YEAR_MIN) && (year <= YEAR_MAX) &&
                (month inside {[MONTH_MIN:MONTH_MAX]}) && (day >= DAY_MIN);
    yy_next   = (month <= MONTH_FEB) ? year - YEAR_W'(1) : year;
    midx_next = month - MONTH_W'(1);
    prod100   = yy_next * RECIP_100;
    q100_next = Q100_W'(prod100 >> SHIFT_100);
  end

  always_ff @(posedge clk) begin
    if (ctl.ld2) begin
      yy   <= yy_next;
      midx <= midx_next;
      q100 <= q100_next;
      dy   <= day;
      ok2  <= ok_next;
    end
  end

  always_comb begin
    leap = LEAP_W'(yy >> 2) - LEAP_W'(q100) + LEAP_W'(q100 >> 2);
    serial_next = SERIAL_W'(yy) * SERIAL_W'(DAYS_PER_YEAR) + SERIAL_W'(leap) +
                  SERIAL_W'(days_before_month(midx)) + SERIAL_W'(dy);
    wsum_next   = yy + WSUM_W'(leap) + WSUM_W'(weekday_offset(midx)) + WSUM_W'(dy);
  end

  always_ff @(posedge clk) begin
    if (ctl.ld3) begin
      serial <= serial_next;
      wsum   <= wsum_next;
      ok     <= ok2;
    end
  end

endmodule

`default_nettype wire

// File: verif/date_difference_and_weekday_checker.sv
// Result checker for date_difference_and_weekday: watches both stream channels,
// predicts the day span and weekdays of every accepted date pair and compares in order.
// Depends on dwd_pkg for widths only.
module date_difference_and_weekday_checker (
  input  wire                            clk,
  input  wire                            rst,
  input  wire                            s_axis_tvalid,
  input  wire                            s_axis_tready,
  // [13:0] first_year, [17:14] first_month, [22:18] first_day, [36:23] second_year,
  // [40:37] second_month, [45:41] second_day, [47:46] zero
  input  wire  [dwd_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  input  wire                            m_axis_tvalid,
  input  wire                            m_axis_tready,
  // [21:0] days_between, [24:22] first_weekday, [27:25] second_weekday, [31:28] zero
  input  wire  [dwd_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  // [0] valid_res
  input  wire                            m_axis_tuser,
  output int                             mismatches,
  output int                             outstanding
);
  import dwd_pkg::*;

  typedef struct packed {
    logic [SERIAL_W-1:0] span;
    logic [WDAY_W-1:0]   wday_first;
    logic [WDAY_W-1:0]   wday_second;
    logic                ok;
  } date_result_t;

  date_result_t pending_spans[$];

  function automatic bit date_in_range(input int unsigned y, input int unsigned m,
                                       input int unsigned d);
    return y >= 1 && y <= 9999 && m >= 1 && m <= 12 && d >= 1 && d <= 31;
  endfunction

  function automatic int unsigned leap_days(input int unsigned yy);
    return yy / 4 - yy / 100 + yy / 400;
  endfunction

  // Day count before the first of each month in a non-leap year.
  function automatic int unsigned month_start_days(input int unsigned m);
    int unsigned n;
    case (m)
      1:       n = 0;
      2:       n = 31;
      3:       n = 59;
      4:       n = 90;
      5:       n = 120;
      6:       n = 151;
      7:       n = 181;
      8:       n = 212;
      9:       n = 243;
      10:      n = 273;
      11:      n = 304;
      default: n = 334;
    endcase
    return n;
  endfunction

  // Per-month weekday shift of the Sakamoto method.
  function automatic int unsigned month_weekday_shift(input int unsigned m);
    int unsigned n;
    case (m)
      1:       n = 0;
      2:       n = 3;
      3:       n = 2;
      4:       n = 5;
      5:       n = 0;
      6:       n = 3;
      7:       n = 5;
      8:       n = 1;
      9:       n = 4;
      10:      n = 6;
      11:      n = 2;
      default: n = 4;
    endcase
    return n;
  endfunction

  // Treat January and February as the tail of the previous year.
  function automatic int unsigned absolute_day(input int unsigned y, input int unsigned m,
                                               input int unsigned d);
    int unsigned yy;
    yy = (m <= 2) ? y - 1 : y;
    return yy * 365 + leap_days(yy) + month_start_days(m) + d;
  endfunction

  function automatic int unsigned day_of_week(input int unsigned y, input int unsigned m,
                                              input int unsigned d);
    int unsigned yy;
    yy = (m <= 2) ? y - 1 : y;
    return (yy + leap_days(yy) + month_weekday_shift(m) + d) % 7;
  endfunction

  function automatic date_result_t predict_span(input logic [IN_DATA_W-1:0] word);
    int unsigned  y1, m1, d1, y2, m2, d2, a, b;
    date_result_t res;
    y1  = word[13:0];
    m1  = word[17:14];
    d1  = word[22:18];
    y2  = word[36:23];
    m2  = word[40:37];
    d2  = word[45:41];
    res = '0;
    if (date_in_range(y1, m1, d1) && date_in_range(y2, m2, d2)) begin
      a               = absolute_day(y1, m1, d1);
      b               = absolute_day(y2, m2, d2);
      res.span        = SERIAL_W'((b >= a) ? b - a : a - b);
      res.wday_first  = WDAY_W'(day_of_week(y1, m1, d1));
      res.wday_second = WDAY_W'(day_of_week(y2, m2, d2));
      res.ok          = 1'b1;
    end
    return res;
  endfunction

  always @(posedge clk) begin
    date_result_t want;
    date_result_t got;
    if (rst) begin
      pending_spans.delete();
      mismatches  = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready)
        pending_spans.push_back(predict_span(s_axis_tdata));
      if (m_axis_tvalid && m_axis_tready) begin
        got.span        = m_axis_tdata[21:0];
        got.wday_first  = m_axis_tdata[24:22];
        got.wday_second = m_axis_tdata[27:25];
        got.ok          = m_axis_tuser;
        if (pending_spans.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected word: span %0d wd %0d/%0d ok %0b", $time,
                   got.span, got.wday_first, got.wday_second, got.ok);
        end else begin
          want = pending_spans.pop_front();
          if (got != want) begin
            mismatches++;
            $display({"%0t: mismatch: expected span %0d wd %0d/%0d ok %0b, ",
                      "got span %0d wd %0d/%0d ok %0b"},
                     $time, want.span, want.wday_first, want.wday_second, want.ok,
                     got.span, got.wday_first, got.wday_second, got.ok);
          end
        end
      end
    end
    outstanding = pending_spans.size();
  end

endmodule

// File: verif/date_difference_and_weekday_tb.sv
// Testbench top for date_difference_and_weekday: drives date pairs with random
// gaps and back-pressure and gives the verdict.
// Depends on dwd_pkg, the block and date_difference_and_weekday_checker.
module date_difference_and_weekday_tb;
  import dwd_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_PER_PHASE = 650;

  logic                  clk;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic                  m_axis_tready = 1'b0;
  wire                   s_axis_tready;
  wire                   m_axis_tvalid;
  wire  [OUT_DATA_W-1:0] m_axis_tdata;
  wire                   m_axis_tuser;

  int send_idle_pct = 30;
  int recv_idle_pct = 61;
  bit hold_request  = 1'b0;
  int mismatches;
  int outstanding;
  int cycle_count;

  date_difference_and_weekday dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  date_difference_and_weekday_checker result_check (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .mismatches    (mismatches),
    .outstanding   (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Regression FAIL");
    $finish;
  end

  // Output side: random stalls, plus one long hold-off on request.
  initial begin
    int hold_left;
    hold_left = 0;
    wait (!rst);
    @(negedge clk);
    forever begin
      if (hold_request) begin
        hold_left    = 300;
        hold_request = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready = 1'b0;
      end else begin
        m_axis_tready = ($urandom_range(99) >= recv_idle_pct);
      end
      @(negedge clk);
    end
  end

  task automatic send_dates(input logic [YEAR_W-1:0] y1, input logic [MONTH_W-1:0] m1,
                            input logic [DAY_W-1:0] d1, input logic [YEAR_W-1:0] y2,
                            input logic [MONTH_W-1:0] m2, input logic [DAY_W-1:0] d2);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid = 1'b0;
      s_axis_tdata  = IN_DATA_W'({$urandom, $urandom});
      @(negedge clk);
    end
    s_axis_tdata  = {2'b00, d2, m2, y2, d1, m1, y1};
    s_axis_tvalid = 1'b1;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic [YEAR_W-1:0] pick_year();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 3)
      return YEAR_W'($urandom_range(16383));
    if (r < 8) begin
      case ($urandom_range(8))
        0:       return YEAR_W'(0);
        1:       return YEAR_W'(1);
        2:       return YEAR_W'(2);
        3:       return YEAR_W'(400);
        4:       return YEAR_W'(1900);
        5:       return YEAR_W'(9998);
        6:       return YEAR_W'(9999);
        7:       return YEAR_W'(10000);
        default: return YEAR_W'(16383);
      endcase
    end
    return YEAR_W'($urandom_range(9999, 1));
  endfunction

  function automatic logic [MONTH_W-1:0] pick_month();
    if ($urandom_range(99) < 4)
      return MONTH_W'($urandom_range(15));
    return MONTH_W'($urandom_range(12, 1));
  endfunction

  function automatic logic [DAY_W-1:0] pick_day();
    if ($urandom_range(99) < 4)
      return DAY_W'($urandom_range(31));
    return DAY_W'($urandom_range(31, 1));
  endfunction

  task automatic send_random_pairs(input int count);
    logic [YEAR_W-1:0]  y1, y2;
    logic [MONTH_W-1:0] m1, m2;
    logic [DAY_W-1:0]   d1, d2;
    repeat (count) begin
      y1 = pick_year();
      m1 = pick_month();
      d1 = pick_day();
      if ($urandom_range(99) < 25) begin
        // Keep the second date near the first: same year, same or next month.
        y2 = y1;
        m2 = (m1 < MONTH_W'(12) && $urandom_range(1)) ? m1 + MONTH_W'(1) : m1;
        d2 = pick_day();
      end else begin
        y2 = pick_year();
        m2 = pick_month();
        d2 = pick_day();
      end
      send_dates(y1, m1, d1, y2, m2, d2);
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    send_dates(1, 1, 1, 1, 1, 1);
    send_dates(9999, 12, 31, 1, 1, 1);
    send_dates(2000, 2, 29, 2000, 3, 1);
    send_dates(1900, 2, 28, 1900, 3, 1);
    send_dates(2024, 4, 31, 2024, 5, 1);
    send_dates(1, 2, 31, 9999, 2, 29);
    send_dates(2020, 0, 10, 2020, 1, 10);
    send_dates(2020, 13, 10, 2020, 1, 10);
    send_dates(2020, 15, 31, 2020, 1, 10);
    send_dates(2020, 6, 0, 2020, 6, 1);
    send_dates(0, 6, 1, 2020, 6, 1);
    send_dates(2020, 6, 1, 10000, 6, 1);
    send_dates(16383, 15, 31, 16383, 15, 31);
    for (int m = 1; m <= 12; m++)
      send_dates(2023, MONTH_W'(m), 15, 2024, MONTH_W'(13 - m), 1);

    // Stall the output for a long stretch while words keep coming in.
    hold_request = 1'b1;
    send_random_pairs(RANDOM_PER_PHASE);

    send_idle_pct = 61;
    recv_idle_pct = 30;
    send_random_pairs(RANDOM_PER_PHASE);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_random_pairs(RANDOM_PER_PHASE);

    s_axis_tvalid = 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (10) @(negedge clk);

    if (mismatches == 0 && outstanding == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
